// File: rtl/rfa_pkg.sv
`timescale 1ns / 1ps

package rfa_pkg;

   localparam int DATA_W     = 32;
   localparam int FIELD_W    = 5;
   localparam int OP_W       = 5;
   localparam int REQ_DATA_W = 48;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [DATA_W-1:0] word_type;

   localparam op_type OP_ADD   = 5'd0;
   localparam op_type OP_SUB   = 5'd1;
   localparam op_type OP_MUL   = 5'd2;
   localparam op_type OP_MOV   = 5'd3;
   localparam op_type OP_DEC   = 5'd4;
   localparam op_type OP_EQ    = 5'd5;
   localparam op_type OP_LT    = 5'd6;
   localparam op_type OP_GT    = 5'd7;
   localparam op_type OP_LTE   = 5'd8;
   localparam op_type OP_GTE   = 5'd9;
   localparam op_type OP_AND   = 5'd10;
   localparam op_type OP_OR    = 5'd11;
   localparam op_type OP_XOR   = 5'd12;
   localparam op_type OP_NOT   = 5'd13;
   localparam op_type OP_LSH   = 5'd14;
   localparam op_type OP_RSH   = 5'd15;
   localparam op_type OP_ST    = 5'd16;
   localparam op_type OP_XCHG  = 5'd17;
   localparam op_type OP_DIV   = 5'd18;
   localparam op_type OP_REM   = 5'd19;
   localparam op_type OP_WRITE = 5'd20;
   localparam op_type OP_READ  = 5'd21;

   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_DIV_ZERO = 1'b1;

endpackage

// File: rtl/register_file_alu_execute.sv
`timescale 1ns / 1ps

// Register-to-register execute unit with a register file of NUM_REGS signed
// 32-bit registers. Each request transaction carries an operation code in
// req_tuser and the register indexes and host write value in req_tdata.
// Each request produces exactly one response transaction with the value
// written (or read) in rsp_tdata and the divide-by-zero flag in rsp_tuser.
// A request is taken, the register file is read into the memories' output
// registers, and the result is then registered into the response register;
// the next request is taken only once the current one has completed. An
// exchange adds a state for its second write. Divide and remainder run
// through a one-bit-per-cycle divider before the response is registered.
// The register file is a pair of single-read-port memories written in
// parallel; per-register valid bits make unwritten registers read as zero.
// Reset clears the valid bits and control state at once, so the block
// takes requests as soon as reset is released. When the receiver stalls,
// the response is held and the next request is still taken; it then waits
// for the output register to drain before completing.
module register_file_alu_execute import rfa_pkg::*; #(
   parameter int NUM_REGS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // dst_reg [4:0], src_a_reg [9:5], src_b_reg [14:10], write_value [46:15]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type [4:0]
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_value [31:0]
   output logic [DATA_W-1:0]     rsp_tdata,
   // status [0]
   output logic [0:0]            rsp_tuser
);

   localparam int IDX_W = $clog2(NUM_REGS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_DONE = 3'd3;
   localparam logic [2:0] S_XCHG = 3'd4;

   function automatic logic [32*IDX_W-1:0] build_map();
      logic [IDX_W-1:0]   r;
      logic [32*IDX_W-1:0] m;
      r = '0;
      m = '0;
      for (int v = 0; v < 32; v++) begin
         m[v*IDX_W +: IDX_W] = r;
         r = (r == IDX_W'(NUM_REGS - 1)) ? '0 : r + 1'b1;
      end
      return m;
   endfunction

   localparam logic [32*IDX_W-1:0] IDX_MAP = build_map();

   logic [2:0]          state_ff, state_in;
   op_type              op_ff;
   logic [IDX_W-1:0]    d_ff, a_ff, b_ff;
   word_type            wval_ff;
   logic                vld_a_ff, vld_b_ff;
   logic [NUM_REGS-1:0] vld_ff;
   word_type            res_ff;
   logic                rsp_valid_ff;
   word_type            rsp_data_ff;
   logic                rsp_status_ff;

   logic [FIELD_W-1:0]  f_d, f_a, f_b;
   logic [IDX_W-1:0]    map_d, map_a, map_b, rd_addr_a;
   op_type              req_op;
   logic                accept;
   logic                out_free;
   word_type            q_a, q_b, va, vb, mul_lo, res;
   logic                do_write, div_zero, div_nz, exec_commit, commit;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   word_type            wr_data;
   logic                div_done;
   word_type            div_q, div_r;

   assign f_d    = req_tdata[4:0];
   assign f_a    = req_tdata[9:5];
   assign f_b    = req_tdata[14:10];
   assign req_op = req_tuser;
   assign map_d  = IDX_MAP[f_d*IDX_W +: IDX_W];
   assign map_a  = IDX_MAP[f_a*IDX_W +: IDX_W];
   assign map_b  = IDX_MAP[f_b*IDX_W +: IDX_W];
   assign rd_addr_a = (req_op == OP_DEC || req_op == OP_READ) ? map_d : map_a;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   rfa_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr_a),
      .rd_data (q_a)
   );

   rfa_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (map_b),
      .rd_data (q_b)
   );

   assign va     = vld_a_ff ? q_a : '0;
   assign vb     = vld_b_ff ? q_b : '0;
   assign mul_lo = va * vb;

   always_comb begin
      res      = '0;
      do_write = 1'b1;
      div_zero = 1'b0;
      div_nz   = 1'b0;
      case (op_ff)
         OP_ADD:   res = va + vb;
         OP_SUB:   res = va - vb;
         OP_MUL:   res = mul_lo;
         OP_MOV:   res = va;
         OP_DEC:   res = va - 1'b1;
         OP_EQ:    res = DATA_W'(va == vb);
         OP_LT:    res = DATA_W'($signed(va) < $signed(vb));
         OP_GT:    res = DATA_W'($signed(va) > $signed(vb));
         OP_LTE:   res = DATA_W'($signed(va) <= $signed(vb));
         OP_GTE:   res = DATA_W'($signed(va) >= $signed(vb));
         OP_AND:   res = va & vb;
         OP_OR:    res = va | vb;
         OP_XOR:   res = va ^ vb;
         OP_NOT:   res = DATA_W'(va == '0);
         OP_LSH:   res = va << vb[4:0];
         OP_RSH:   res = word_type'($signed(va) >>> vb[4:0]);
         OP_ST:    res = vb;
         OP_XCHG:  res = vb;
         OP_DIV, OP_REM: begin
            if (vb == '0) begin
               div_zero = 1'b1;
               do_write = 1'b0;
            end else begin
               div_nz = 1'b1;
            end
         end
         OP_WRITE: res = wval_ff;
         OP_READ: begin
            res      = va;
            do_write = 1'b0;
         end
         default:  do_write = 1'b0;
      endcase
   end

   assign exec_commit = (state_ff == S_EXEC) && !div_nz && out_free;
   assign commit      = exec_commit || ((state_ff == S_DONE) && out_free);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = d_ff;
      wr_data = res;
      if (exec_commit) begin
         wr_en   = do_write;
         wr_addr = (op_ff == OP_ST || op_ff == OP_XCHG) ? a_ff : d_ff;
      end else if (state_ff == S_DONE) begin
         wr_en   = out_free;
         wr_data = res_ff;
      end else if (state_ff == S_XCHG) begin
         wr_en   = 1'b1;
         wr_addr = b_ff;
         wr_data = va;
      end
   end

   rfa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     ((state_ff == S_EXEC) && div_nz),
      .dividend  (va),
      .divisor   (vb),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_EXEC;
         S_EXEC: begin
            if (div_nz) begin
               state_in = S_DIV;
            end else if (out_free) begin
               state_in = (op_ff == OP_XCHG) ? S_XCHG : S_IDLE;
            end
         end
         S_DIV:  if (div_done) state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         S_XCHG: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         d_ff     <= map_d;
         a_ff     <= map_a;
         b_ff     <= map_b;
         wval_ff  <= req_tdata[46:15];
         vld_a_ff <= vld_ff[rd_addr_a];
         vld_b_ff <= vld_ff[map_b];
      end
      if (state_ff == S_DIV && div_done) begin
         res_ff <= (op_ff == OP_DIV) ? div_q : div_r;
      end
      if (exec_commit) begin
         rsp_data_ff   <= res;
         rsp_status_ff <= div_zero ? STATUS_DIV_ZERO : STATUS_DONE;
      end else if (state_ff == S_DONE && out_free) begin
         rsp_data_ff   <= res_ff;
         rsp_status_ff <= STATUS_DONE;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: rtl/rfa_ram.sv
`timescale 1ns / 1ps

module rfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rfa_div.sv
`timescale 1ns / 1ps

module rfa_div import rfa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type dividend,
   input  word_type divisor,
   output logic     done,
   output word_type quotient,
   output word_type remainder
);

   logic             busy_ff;
   logic             done_ff;
   logic [4:0]       cnt_ff;
   word_type         dvd_ff;
   word_type         dvs_ff;
   word_type         rem_ff;
   logic             neg_q_ff;
   logic             neg_r_ff;
   logic [DATA_W:0]  rem_sh;
   logic [DATA_W:0]  diff;
   logic             qbit;

   assign rem_sh = {rem_ff, dvd_ff[DATA_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign qbit   = ~diff[DATA_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff   <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         dvs_ff   <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
         rem_ff   <= '0;
         neg_q_ff <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
         neg_r_ff <= dividend[DATA_W-1];
      end else if (busy_ff) begin
         rem_ff <= qbit ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
         dvd_ff <= {dvd_ff[DATA_W-2:0], qbit};
      end
   end

   assign done      = done_ff;
   assign quotient  = neg_q_ff ? (~dvd_ff + 1'b1) : dvd_ff;
   assign remainder = neg_r_ff ? (~rem_ff + 1'b1) : rem_ff;

endmodule

// File: rtl/rfa_checker.sv
`timescale 1ns / 1ps

module rfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic [4:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // A stalled response stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response payload changed while stalled");

   // A divide by zero reports a zero result.
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("divide-by-zero response with nonzero value");

   // The unit works on one request at a time, so two transactions never
   // follow back to back.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is executing");

endmodule

bind register_file_alu_execute rfa_checker u_rfa_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top import rfa_pkg::*; ();

   typedef struct {
      word_type value;
      logic     status;
   } exec_result_type;

   localparam word_type INT_MIN_W   = 32'h8000_0000;
   localparam word_type INT_MAX_W   = 32'h7FFF_FFFF;
   localparam word_type MINUS_ONE_W = 32'hFFFF_FFFF;
   localparam op_type   OP_UNUSED_LO = 5'd22;
   localparam op_type   OP_UNUSED_HI = 5'd31;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;
   logic [0:0]            rsp_tuser;

   word_type        reg_model [32];
   exec_result_type expected_results [$];
   int              req_idle_pct   = 0;
   int              rsp_stall_pct  = 0;
   int              mismatch_count = 0;
   int              items_sent     = 0;
   int              directed_items = 0;
   int              results_checked = 0;
   int              div_zero_seen  = 0;

   register_file_alu_execute #(.NUM_REGS(32)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic exec_result_type predict_exec(input op_type op, input logic [4:0] d,
                                                    input logic [4:0] a, input logic [4:0] b,
                                                    input word_type wv);
      exec_result_type   r;
      word_type          va;
      word_type          vb;
      logic signed [31:0] sa;
      logic signed [31:0] sb;
      logic              write_dst;
      va = reg_model[a];
      vb = reg_model[b];
      sa = va;
      sb = vb;
      r.value = '0;
      r.status = STATUS_DONE;
      write_dst = 1'b1;
      case (op)
         OP_ADD:   r.value = va + vb;
         OP_SUB:   r.value = va - vb;
         OP_MUL:   r.value = va * vb;
         OP_MOV:   r.value = va;
         OP_DEC:   r.value = reg_model[d] - 32'd1;
         OP_EQ:    r.value = {31'd0, sa == sb};
         OP_LT:    r.value = {31'd0, sa < sb};
         OP_GT:    r.value = {31'd0, sa > sb};
         OP_LTE:   r.value = {31'd0, sa <= sb};
         OP_GTE:   r.value = {31'd0, sa >= sb};
         OP_AND:   r.value = va & vb;
         OP_OR:    r.value = va | vb;
         OP_XOR:   r.value = va ^ vb;
         OP_NOT:   r.value = {31'd0, va == '0};
         OP_LSH:   r.value = va << vb[4:0];
         OP_RSH:   r.value = sa >>> vb[4:0];
         OP_ST: begin
            r.value = vb;
            reg_model[a] = vb;
            write_dst = 1'b0;
         end
         OP_XCHG: begin
            r.value = vb;
            reg_model[a] = vb;
            reg_model[b] = va;
            write_dst = 1'b0;
         end
         OP_DIV, OP_REM: begin
            if (vb == '0) begin
               r.status = STATUS_DIV_ZERO;
               write_dst = 1'b0;
            end else if (va == INT_MIN_W && vb == MINUS_ONE_W) begin
               r.value = (op == OP_DIV) ? INT_MIN_W : '0;
            end else if (op == OP_DIV) begin
               r.value = sa / sb;
            end else begin
               r.value = sa % sb;
            end
         end
         OP_WRITE: r.value = wv;
         OP_READ: begin
            r.value = reg_model[d];
            write_dst = 1'b0;
         end
         default:  write_dst = 1'b0;
      endcase
      if (write_dst) begin
         reg_model[d] = r.value;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic send_item(input op_type op, input logic [4:0] d, input logic [4:0] a,
                            input logic [4:0] b, input word_type wv);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, wv, b, a, d};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      expected_results.push_back(predict_exec(op, d, a, b, wv));
      items_sent++;
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : check_responses
      exec_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response value %h status %0d",
                                      rsp_tdata, rsp_tuser));
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (want.status == STATUS_DIV_ZERO) begin
               div_zero_seen++;
            end
            if (rsp_tdata !== want.value) begin
               report_mismatch($sformatf("result_value %h, expected %h",
                                         rsp_tdata, want.value));
            end
            if (rsp_tuser[0] !== want.status) begin
               report_mismatch($sformatf("status %b, expected %b",
                                         rsp_tuser[0], want.status));
            end
         end
      end
   end

   function automatic word_type pick_value();
      case ($urandom_range(7))
         0:       return INT_MIN_W;
         1:       return INT_MAX_W;
         2:       return MINUS_ONE_W;
         3:       return '0;
         4:       return 32'd1;
         5:       return $urandom_range(63);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [4:0] pick_reg();
      if ($urandom_range(1) == 0) begin
         return 5'($urandom_range(7));
      end
      return 5'($urandom_range(31));
   endfunction

   task automatic test_host_access();
      send_item(OP_WRITE, 5'd1, 5'd0, 5'd0, INT_MIN_W);
      send_item(OP_WRITE, 5'd2, 5'd31, 5'd31, MINUS_ONE_W);
      send_item(OP_WRITE, 5'd3, 5'd0, 5'd0, INT_MAX_W);
      send_item(OP_READ, 5'd1, 5'd0, 5'd0, '0);
      send_item(OP_READ, 5'd9, 5'd0, 5'd0, '0);
   endtask

   task automatic test_operations();
      send_item(OP_ADD, 5'd4, 5'd3, 5'd2, '0);
      send_item(OP_SUB, 5'd1, 5'd1, 5'd2, '0);
      send_item(OP_MUL, 5'd6, 5'd3, 5'd3, '0);
      send_item(OP_DEC, 5'd0, 5'd0, 5'd0, '0);
      send_item(OP_EQ, 5'd8, 5'd2, 5'd2, '0);
      send_item(OP_LT, 5'd9, 5'd1, 5'd3, '0);
      send_item(OP_GT, 5'd10, 5'd1, 5'd3, '0);
      send_item(OP_LTE, 5'd11, 5'd3, 5'd3, '0);
      send_item(OP_GTE, 5'd12, 5'd2, 5'd3, '0);
      send_item(OP_AND, 5'd13, 5'd3, 5'd2, '0);
      send_item(OP_OR, 5'd14, 5'd1, 5'd3, '0);
      send_item(OP_XOR, 5'd31, 5'd3, 5'd2, '0);
      send_item(OP_MOV, 5'd7, 5'd31, 5'd0, '0);
      send_item(OP_NOT, 5'd15, 5'd20, 5'd0, '0);
      send_item(OP_LSH, 5'd16, 5'd2, 5'd3, '0);
      send_item(OP_RSH, 5'd17, 5'd2, 5'd3, '0);
      send_item(OP_ST, 5'd0, 5'd20, 5'd3, '0);
      send_item(OP_XCHG, 5'd0, 5'd21, 5'd3, '0);
   endtask

   task automatic test_special_cases();
      send_item(OP_WRITE, 5'd1, 5'd0, 5'd0, INT_MIN_W);
      send_item(OP_DIV, 5'd18, 5'd1, 5'd2, '0);
      send_item(OP_REM, 5'd19, 5'd1, 5'd2, '0);
      send_item(OP_DIV, 5'd22, 5'd21, 5'd25, '0);
      send_item(OP_REM, 5'd22, 5'd21, 5'd25, '0);
      send_item(OP_UNUSED_HI, 5'd21, 5'd2, 5'd3, 32'h1234_5678);
      send_item(OP_XCHG, 5'd0, 5'd2, 5'd2, '0);
   endtask

   task automatic test_random_mix(input int count, input int idle_pct, input int stall_pct);
      op_type op;
      int     pick;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            op = OP_WRITE;
         end else if (pick < 18) begin
            op = op_type'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
         end else begin
            op = op_type'($urandom_range(OP_READ));
         end
         send_item(op, pick_reg(), pick_reg(), pick_reg(),
                   (op == OP_WRITE) ? pick_value() : word_type'($urandom));
      end
   endtask

   initial begin
      foreach (reg_model[i]) begin
         reg_model[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_host_access();
      test_operations();
      test_special_cases();
      directed_items = items_sent;
      test_random_mix(470, 0, 0);
      test_random_mix(470, 53, 0);
      test_random_mix(470, 0, 53);
      test_random_mix(470, 20, 20);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (60) @(posedge clock);
      $display("Sent %0d requests (%0d directed) under four sender/receiver pressure phases.",
               items_sent, directed_items);
      $display("Checked %0d responses, %0d of them divide-by-zero.",
               results_checked, div_zero_seen);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/rfa_pkg.sv
rtl/rfa_ram.sv
rtl/rfa_div.sv
rtl/register_file_alu_execute.sv
rtl/rfa_checker.sv
test/tb_top.sv
